/* hdl/tcon_pkg.sv */
// Package for the text console: constants, state and sequence enums, command/status structs.
// No dependencies.
`default_nettype none
package tcon_pkg;
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int ESC_MAX_DEF = 15;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] TAB_BYTE  = 8'h09;
  localparam logic [7:0] BS_BYTE   = 8'h08;
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] DEF_ATTR  = 8'h07;
  localparam int TAB_SPACES = 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_RDWAIT, ST_TAB, ST_SCR_RD, ST_SCR_WR,
    ST_FILL, ST_OUT
  } tcon_state_t;

  typedef enum logic [1:0] {
    SEQ_NONE, SEQ_CLEAR, SEQ_HOME, SEQ_ERASE
  } tcon_seq_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic rd_issue;    // issue read of requested cell
    logic rd_capture;  // capture read data
    logic put;         // execute put byte (single-cycle part)
    logic tab_put;     // write one tab space
    logic scr_start;   // begin scroll
    logic scr_rd;      // read source cell
    logic scr_wr;      // write dest cell
    logic fill_start;  // begin fill (clear or erase)
    logic fill_step;   // write one blank
    logic out_load;    // present result
  } tcon_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic need_tab;
    logic need_scroll;
    logic need_fill;
    logic tab_last;
    logic scr_last;
    logic fill_last;
    logic out_busy;
    logic init_busy;   // reset clearing pass running
  } tcon_sts_t;
endpackage
`default_nettype wire

/* hdl/tcon_ctrl.sv */
// Controller state machine for the text console.
// Depends on tcon_pkg.
`default_nettype none
module tcon_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    ready,
  input  wire tcon_pkg::tcon_sts_t sts,
  output tcon_pkg::tcon_cmd_t     cmd
);
  tcon_pkg::tcon_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tcon_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      tcon_pkg::ST_IDLE:   if (valid && !sts.init_busy) state_next = tcon_pkg::ST_DECODE;
      tcon_pkg::ST_DECODE: state_next = sts.is_read ? tcon_pkg::ST_RDWAIT : tcon_pkg::ST_TAB;
      tcon_pkg::ST_RDWAIT: state_next = tcon_pkg::ST_OUT;
      tcon_pkg::ST_TAB: begin
        if (sts.need_scroll) state_next = tcon_pkg::ST_SCR_RD;
        else if (sts.need_fill) state_next = tcon_pkg::ST_FILL;
        else if (sts.need_tab && !sts.tab_last) state_next = tcon_pkg::ST_TAB;
        else state_next = tcon_pkg::ST_OUT;
      end
      tcon_pkg::ST_SCR_RD: state_next = tcon_pkg::ST_SCR_WR;
      tcon_pkg::ST_SCR_WR: begin
        if (sts.scr_last) state_next = tcon_pkg::ST_FILL;
        else state_next = tcon_pkg::ST_SCR_RD;
      end
      tcon_pkg::ST_FILL: begin
        if (sts.fill_last)
          state_next = (sts.need_tab && !sts.tab_last) ? tcon_pkg::ST_TAB
                                                      : tcon_pkg::ST_OUT;
      end
      tcon_pkg::ST_OUT: if (!sts.out_busy) state_next = tcon_pkg::ST_IDLE;
      default: state_next = tcon_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    ready = 1'b0;
    case (state)
      tcon_pkg::ST_IDLE: begin
        ready = !sts.init_busy;
        cmd.load = valid && !sts.init_busy;
      end
      tcon_pkg::ST_DECODE: begin
        cmd.rd_issue = sts.is_read;
        cmd.put = !sts.is_read;
      end
      tcon_pkg::ST_RDWAIT: cmd.rd_capture = 1'b1;
      tcon_pkg::ST_TAB: begin
        if (sts.need_scroll) cmd.scr_start = 1'b1;
        else if (sts.need_fill) cmd.fill_start = 1'b1;
        else if (sts.need_tab && !sts.tab_last) cmd.tab_put = 1'b1;
      end
      tcon_pkg::ST_SCR_RD: cmd.scr_rd = 1'b1;
      tcon_pkg::ST_SCR_WR: cmd.scr_wr = 1'b1;
      tcon_pkg::ST_FILL: cmd.fill_step = 1'b1;
      tcon_pkg::ST_OUT: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/tcon_dp.sv */
// Datapath for the text console: cell memory, cursor, escape buffer, output register.
// Depends on tcon_pkg.
`default_nettype none
module tcon_dp #(
  parameter int COLUMNS = tcon_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcon_pkg::ROWS_DEF,
  parameter int ESC_MAX = tcon_pkg::ESC_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcon_pkg::tcon_cmd_t cmd,
  output tcon_pkg::tcon_sts_t     sts,
  input  wire logic               action,
  input  wire logic [7:0]         char_code,
  input  wire logic [4:0]         read_row,
  input  wire logic [6:0]         read_col,
  output logic                    valid_out,
  input  wire logic               ready_out,
  output logic [7:0]              cell_char,
  output logic [7:0]              cell_attr,
  output logic [4:0]              cursor_row,
  output logic [6:0]              cursor_col,
  output logic                    in_escape
);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int EW = $clog2(ESC_MAX + 1);
  localparam int EIW = $clog2(ESC_MAX);
  localparam int SCR_END = (ROWS - 1) * COLUMNS;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;

  logic          r_act;
  logic [7:0]    r_char;
  logic [4:0]    r_rrow;
  logic [6:0]    r_rcol;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [7:0]    attribute;
  logic          esc_act;
  logic [7:0]    esc_buf [ESC_MAX];
  logic [EW-1:0] esc_len;
  logic          esc_ovf;
  logic [2:0]    tab_cnt;
  logic          tab_mode;
  logic          scr_pend;
  logic          fill_pend;
  logic [AW-1:0] fill_addr;
  logic [AW-1:0] fill_end;
  logic [AW-1:0] scr_addr;
  logic          rd_oob;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  logic [7:0]    cap_char;
  logic [7:0]    cap_attr;

  logic [AW-1:0] cur_addr;
  assign cur_addr = AW'(cur_row * COLUMNS) + AW'(cur_col);

  // sequence recognition
  function automatic logic eq(input logic [7:0] a, input logic [7:0] b);
    return a == b;
  endfunction

  logic [7:0] b0, b1, b2, b3;
  assign b0 = esc_buf[0];
  assign b1 = esc_buf[1];
  assign b2 = esc_buf[2];
  assign b3 = r_char;

  logic        is_term;
  logic [EW-1:0] len_after;
  assign is_term = (r_char == "m") || (r_char == "J") || (r_char == "H") || (r_char == "K");
  assign len_after = (esc_len < EW'(ESC_MAX)) ? esc_len + 1'b1 : esc_len;

  logic       set_attr;
  logic [7:0] new_attr;
  tcon_pkg::tcon_seq_t seq;
  always_comb begin
    set_attr = 1'b0;
    new_attr = attribute;
    seq = tcon_pkg::SEQ_NONE;
    if (len_after == EW'(3) && eq(b0, "[") && eq(b1, "0") && eq(b3, "m")) begin
      set_attr = 1'b1; new_attr = tcon_pkg::DEF_ATTR;
    end else if (len_after == EW'(4) && eq(b0, "[") && eq(b1, "3") && eq(b3, "m")) begin
      case (b2)
        "7": begin set_attr = 1'b1; new_attr = 8'h07; end
        "1": begin set_attr = 1'b1; new_attr = 8'h04; end
        "2": begin set_attr = 1'b1; new_attr = 8'h02; end
        "3": begin set_attr = 1'b1; new_attr = 8'h06; end
        "4": begin set_attr = 1'b1; new_attr = 8'h01; end
        "5": begin set_attr = 1'b1; new_attr = 8'h05; end
        "6": begin set_attr = 1'b1; new_attr = 8'h03; end
        default: ;
      endcase
    end else if (len_after == EW'(3) && eq(b0, "[") && eq(b1, "2") && eq(b3, "J")) begin
      seq = tcon_pkg::SEQ_CLEAR;
    end else if (len_after == EW'(2) && eq(b0, "[") && eq(b3, "H")) begin
      seq = tcon_pkg::SEQ_HOME;
    end else if (len_after == EW'(2) && eq(b0, "[") && eq(b3, "K")) begin
      seq = tcon_pkg::SEQ_ERASE;
    end
  end

  assign sts.is_read     = r_act;
  assign sts.need_tab    = tab_mode;
  assign sts.need_scroll = scr_pend;
  assign sts.need_fill   = fill_pend;
  assign sts.tab_last    = (tab_cnt == 3'(tcon_pkg::TAB_SPACES));
  assign sts.scr_last    = (scr_addr == AW'(SCR_END - 1));
  assign sts.fill_last   = (fill_addr == fill_end) && !clr_busy;
  assign sts.out_busy    = valid_out && !ready_out;
  assign sts.init_busy   = clr_busy;

  // write port selection
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          adv;

  always_comb begin
    we = 1'b0; waddr = cur_addr; wdata = {attribute, r_char}; adv = 1'b0;
    if (clr_busy) begin
      we = 1'b1; waddr = clr_addr; wdata = {tcon_pkg::DEF_ATTR, tcon_pkg::SPACE};
    end else if (cmd.put && !esc_act && r_char != tcon_pkg::ESC_BYTE) begin
      case (r_char)
        tcon_pkg::LF_BYTE, tcon_pkg::CR_BYTE, tcon_pkg::TAB_BYTE: ;
        tcon_pkg::BS_BYTE: if (cur_col != '0) begin
          we = 1'b1; waddr = cur_addr - 1'b1; wdata = {attribute, tcon_pkg::SPACE};
        end
        default: begin we = 1'b1; adv = 1'b1; end
      endcase
    end else if (cmd.tab_put) begin
      we = 1'b1; wdata = {attribute, tcon_pkg::SPACE}; adv = 1'b1;
    end else if (cmd.scr_wr) begin
      we = 1'b1; waddr = scr_addr; wdata = rdata;
    end else if (cmd.fill_step) begin
      we = 1'b1; waddr = fill_addr; wdata = {attribute, tcon_pkg::SPACE};
    end
  end

  logic [AW-1:0] raddr;
  always_comb begin
    if (cmd.scr_rd) raddr = scr_addr + AW'(COLUMNS);
    else raddr = AW'(RW'(r_rrow) * COLUMNS) + AW'(CW'(r_rcol));
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_act <= action; r_char <= char_code; r_rrow <= read_row; r_rcol <= read_col;
    end
    if (cmd.rd_issue)
      rd_oob <= (32'(r_rrow) >= ROWS) || (32'(r_rcol) >= COLUMNS);
    if (cmd.put && esc_act && r_char != tcon_pkg::ESC_BYTE && esc_len < EW'(ESC_MAX))
      esc_buf[EIW'(esc_len)] <= r_char;
  end

  logic at_last_col;
  logic at_last_row;
  assign at_last_col = (cur_col == CW'(COLUMNS - 1));
  assign at_last_row = (cur_row == RW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0; cur_col <= '0; attribute <= tcon_pkg::DEF_ATTR;
      esc_act <= 1'b0; esc_len <= '0; esc_ovf <= 1'b0;
      tab_cnt <= '0; tab_mode <= 1'b0; scr_pend <= 1'b0; fill_pend <= 1'b0;
      fill_addr <= '0; fill_end <= '0; scr_addr <= '0;
      clr_busy <= 1'b1; clr_addr <= '0;
      valid_out <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) clr_busy <= 1'b0;
      end
      if (valid_out && ready_out) valid_out <= 1'b0;
      if (cmd.load) begin
        tab_cnt <= '0; tab_mode <= 1'b0;
      end
      if (cmd.put) begin
        if (r_char == tcon_pkg::ESC_BYTE) begin
          esc_act <= 1'b1; esc_len <= '0; esc_ovf <= 1'b0;
        end else if (esc_act) begin
          esc_len <= len_after;
          if (esc_len == EW'(ESC_MAX)) esc_ovf <= 1'b1;
          if (is_term) begin
            esc_act <= 1'b0; esc_len <= '0; esc_ovf <= 1'b0;
            if (!esc_ovf && esc_len != EW'(ESC_MAX)) begin
              if (set_attr) attribute <= new_attr;
              case (seq)
                tcon_pkg::SEQ_CLEAR: begin
                  cur_row <= '0; cur_col <= '0;
                  fill_pend <= 1'b1; fill_addr <= '0; fill_end <= AW'(DEPTH - 1);
                end
                tcon_pkg::SEQ_HOME: begin cur_row <= '0; cur_col <= '0; end
                tcon_pkg::SEQ_ERASE: begin
                  cur_col <= '0; fill_pend <= 1'b1;
                  fill_addr <= AW'(cur_row * COLUMNS);
                  fill_end <= AW'(cur_row * COLUMNS) + AW'(COLUMNS - 1);
                end
                default: ;
              endcase
            end
          end
        end else begin
          case (r_char)
            tcon_pkg::LF_BYTE: begin
              cur_col <= '0;
              if (at_last_row) scr_pend <= 1'b1;
              else cur_row <= cur_row + 1'b1;
            end
            tcon_pkg::CR_BYTE: cur_col <= '0;
            tcon_pkg::TAB_BYTE: tab_mode <= 1'b1;
            tcon_pkg::BS_BYTE: if (cur_col != '0) cur_col <= cur_col - 1'b1;
            default: ;
          endcase
        end
      end
      if (cmd.tab_put) tab_cnt <= tab_cnt + 1'b1;
      if (adv) begin
        if (at_last_col) begin
          cur_col <= '0;
          if (at_last_row) scr_pend <= 1'b1;
          else cur_row <= cur_row + 1'b1;
        end else cur_col <= cur_col + 1'b1;
      end
      if (cmd.scr_start) begin
        scr_pend <= 1'b0; scr_addr <= '0;
        cur_row <= RW'(ROWS - 1); cur_col <= '0;
      end
      // last row blanking follows the copy directly in ST_FILL
      if (cmd.scr_wr) begin
        scr_addr <= scr_addr + 1'b1;
        if (sts.scr_last) begin
          fill_addr <= AW'(SCR_END); fill_end <= AW'(DEPTH - 1);
        end
      end
      if (cmd.fill_start) fill_pend <= 1'b0;
      if (cmd.fill_step && !clr_busy && fill_addr != fill_end) fill_addr <= fill_addr + 1'b1;
      if (cmd.out_load) valid_out <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      cap_char <= rd_oob ? 8'h00 : rdata[7:0];
      cap_attr <= rd_oob ? 8'h00 : rdata[15:8];
    end else if (cmd.put) begin
      cap_char <= 8'h00; cap_attr <= 8'h00;
    end
    if (cmd.out_load) begin
      cell_char  <= cap_char;
      cell_attr  <= cap_attr;
      cursor_row <= 5'(cur_row);
      cursor_col <= 7'(cur_col);
      in_escape  <= esc_act;
    end
  end

  property p_out_hold;
    @(posedge clk) disable iff (rst) valid_out && !ready_out |=> valid_out;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_cursor_row;
    @(posedge clk) disable iff (rst) 32'(cur_row) < ROWS;
  endproperty
  a_cursor_row: assert property (p_cursor_row) else $error("row out of range");

  property p_cursor_col;
    @(posedge clk) disable iff (rst) 32'(cur_col) < COLUMNS;
  endproperty
  a_cursor_col: assert property (p_cursor_col) else $error("col out of range");
endmodule
`default_nettype wire

/* hdl/text_console_with_ansi_escapes.sv */
// Text console with ANSI escapes: one transaction in, one result out. Uses tcon_pkg/ctrl/dp.
// Flow: reads go ST_DECODE, ST_RDWAIT, ST_OUT; plain bytes go ST_DECODE, ST_TAB, ST_OUT. A tab
// writes one space per ST_TAB pass, a scroll copies cells via ST_SCR_RD/ST_SCR_WR then blanks
// the last row in ST_FILL, a clear blanks every cell, an erase line the cursor row. Throughput:
// one item at a time, held by a waiting result. Reset: synchronous; a clearing pass then fills
// the cell memory with blanks, with in_ready low until it ends.
`default_nettype none
module text_console_with_ansi_escapes #(
  parameter int COLUMNS = tcon_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcon_pkg::ROWS_DEF,
  parameter int ESC_MAX = tcon_pkg::ESC_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       action,
  input  wire logic [7:0] char_code,
  input  wire logic [4:0] read_row,
  input  wire logic [6:0] read_col,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      cell_char,
  output logic [7:0]      cell_attr,
  output logic [4:0]      cursor_row,
  output logic [6:0]      cursor_col,
  output logic            in_escape
);
  tcon_pkg::tcon_cmd_t cmd;
  tcon_pkg::tcon_sts_t sts;

  tcon_ctrl u_ctrl (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready), .sts(sts), .cmd(cmd)
  );

  tcon_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS), .ESC_MAX(ESC_MAX)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .action(action), .char_code(char_code), .read_row(read_row), .read_col(read_col),
    .valid_out(out_valid), .ready_out(out_ready),
    .cell_char(cell_char), .cell_attr(cell_attr),
    .cursor_row(cursor_row), .cursor_col(cursor_col), .in_escape(in_escape)
  );
endmodule
`default_nettype wire
